// File: hdl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce and long press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned BUTTONS   = 7;
  localparam int unsigned PinW      = 7;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebW      = 16;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  localparam logic [DebW-1:0]  DebounceReset  = 16'd50;
  localparam logic [TimeW-1:0] LongPressReset = 32'd1000;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_POLL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_SHORT_EN   = 2'd2,
    REG_LONG_EN    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DebW-1:0]  bounce_window;
    logic [TimeW-1:0] long_press_ms;
    logic [PinW-1:0]  short_enable_mask;
    logic [PinW-1:0]  long_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic edge_hit;
    logic poll;
    logic pin_up;
    logic short_en;
    logic long_en;
  } lane_ctrl_t;

endpackage

// File: hdl/button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Debounce and short/long press detection for a bank of buttons in lanes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i/in_stall_o   | operation, button_index, pin_levels, now_ms
//  out     | output    | out_valid_o/out_stall_i | short_press_mask, long_press_mask
//  cfg     | input     | apb psel/penable        | paddr, pwdata, prdata
//
//  one beat per cycle while in_stall_o is low; every lane evaluates the accepted beat
//  combinationally and, when the output is free, the merged masks are registered at
//  the accepting edge, offered next cycle; while the output is stalled a skid register takes
//  one more beat, after that in_stall_o stays high until the output drains
//  reset clears all per-button state and loads the register defaults
// ----------------------------------------------------------------------------
module button_debounce_long_press_core import bdlp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             operation_i,
  input  logic [IdxW-1:0]  button_index_i,
  input  logic [PinW-1:0]  pin_levels_i,
  input  logic [TimeW-1:0] now_ms_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PinW-1:0]  short_press_mask_o,
  output logic [PinW-1:0]  long_press_mask_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t                 cfg;
  logic                 acc;
  op_e                  op;
  logic [BUTTONS-1:0]   lane_short;
  logic [BUTTONS-1:0]   lane_long;
  logic [PinW-1:0]      res_short;
  logic [PinW-1:0]      res_long;

  logic                 out_valid_q, out_valid_d;
  logic [PinW-1:0]      out_short_q, out_short_d;
  logic [PinW-1:0]      out_long_q, out_long_d;
  logic                 skid_valid_q, skid_valid_d;
  logic [PinW-1:0]      skid_short_q, skid_short_d;
  logic [PinW-1:0]      skid_long_q, skid_long_d;

  bdlp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = skid_valid_q;
  assign acc        = in_valid_i & ~skid_valid_q;
  assign op         = op_e'(operation_i);

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    lane_ctrl_t ctrl;
    assign ctrl.edge_hit = acc && (op == OP_EDGE) && (32'(button_index_i) == i);
    assign ctrl.poll     = acc && (op == OP_POLL);
    if (i < PinW) begin : g_pin
      assign ctrl.pin_up   = pin_levels_i[i];
      assign ctrl.short_en = cfg.short_enable_mask[i];
      assign ctrl.long_en  = cfg.long_enable_mask[i];
    end else begin : g_nopin
      assign ctrl.pin_up   = 1'b0;
      assign ctrl.short_en = 1'b0;
      assign ctrl.long_en  = 1'b0;
    end
    bdlp_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctrl_i          (ctrl),
      .now_ms_i        (now_ms_i),
      .bounce_window_i (cfg.bounce_window),
      .long_press_ms_i (cfg.long_press_ms),
      .short_o         (lane_short[i]),
      .long_o          (lane_long[i])
    );
  end

  // merge lane reports into the result masks
  for (genvar j = 0; j < PinW; j++) begin : g_merge
    if (j < BUTTONS) begin : g_used
      assign res_short[j] = lane_short[j];
      assign res_long[j]  = lane_long[j];
    end else begin : g_unused
      assign res_short[j] = 1'b0;
      assign res_long[j]  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_short_d  = out_short_q;
    out_long_d   = out_long_q;
    skid_valid_d = skid_valid_q;
    skid_short_d = skid_short_q;
    skid_long_d  = skid_long_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d  = skid_valid_q | acc;
      out_short_d  = skid_valid_q ? skid_short_q : res_short;
      out_long_d   = skid_valid_q ? skid_long_q : res_long;
      skid_valid_d = 1'b0;
    end else if (acc) begin
      skid_valid_d = 1'b1;
      skid_short_d = res_short;
      skid_long_d  = res_long;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_short_q  <= out_short_d;
    out_long_q   <= out_long_d;
    skid_short_q <= skid_short_d;
    skid_long_q  <= skid_long_d;
  end

  assign out_valid_o        = out_valid_q;
  assign short_press_mask_o = out_short_q;
  assign long_press_mask_o  = out_long_q;

endmodule

// File: hdl/bdlp_cfg.sv
// ----------------------------------------------------------------------------
// bdlp_cfg
// APB register file holding debounce time, long press time and enable masks.
// ----------------------------------------------------------------------------
module bdlp_cfg import bdlp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DEBOUNCE:   cfg_d.bounce_window     = pwdata[DebW-1:0];
        REG_LONG_PRESS: cfg_d.long_press_ms     = pwdata[TimeW-1:0];
        REG_SHORT_EN:   cfg_d.short_enable_mask = pwdata[PinW-1:0];
        REG_LONG_EN:    cfg_d.long_enable_mask  = pwdata[PinW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE:   prdata = {{(DataW-DebW){1'b0}}, cfg_q.bounce_window};
      REG_LONG_PRESS: prdata = cfg_q.long_press_ms;
      REG_SHORT_EN:   prdata = {{(DataW-PinW){1'b0}}, cfg_q.short_enable_mask};
      REG_LONG_EN:    prdata = {{(DataW-PinW){1'b0}}, cfg_q.long_enable_mask};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounce_window     <= DebounceReset;
      cfg_q.long_press_ms     <= LongPressReset;
      cfg_q.short_enable_mask <= '0;
      cfg_q.long_enable_mask  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hdl/bdlp_lane.sv
// ----------------------------------------------------------------------------
// bdlp_lane
// Per-button lane: debounce filter, press timing and short/long press decision.
// ----------------------------------------------------------------------------
module bdlp_lane import bdlp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lane_ctrl_t       ctrl_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic [DebW-1:0]  bounce_window_i,
  input  logic [TimeW-1:0] long_press_ms_i,
  output logic             short_o,
  output logic             long_o
);

  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             active_q, active_d;
  logic             seen_q, seen_d;
  logic [TimeW-1:0] since_edge;
  logic [TimeW-1:0] held_for;
  logic             edge_ok;
  logic             is_long;

  assign since_edge = now_ms_i - last_edge_q;
  assign held_for   = now_ms_i - start_q;
  assign edge_ok    = since_edge >= {{(TimeW-DebW){1'b0}}, bounce_window_i};
  assign is_long    = (start_q != '0) && (held_for > long_press_ms_i);

  always_comb begin
    last_edge_d = last_edge_q;
    start_d     = start_q;
    active_d    = active_q;
    seen_d      = seen_q;
    short_o     = 1'b0;
    long_o      = 1'b0;
    if (ctrl_i.edge_hit && edge_ok) begin
      last_edge_d = now_ms_i;
      if (!active_q) begin
        active_d = 1'b1;
        start_d  = now_ms_i;
      end
      seen_d = 1'b1;
    end else if (ctrl_i.poll && active_q) begin
      if (!ctrl_i.pin_up) begin
        if (is_long) begin
          long_o   = ctrl_i.long_en;
          active_d = 1'b0;
          start_d  = '0;
        end
      end else begin
        short_o  = seen_q & ctrl_i.short_en & (held_for <= long_press_ms_i);
        active_d = 1'b0;
        seen_d   = 1'b0;
        start_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      start_q     <= '0;
      active_q    <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      last_edge_q <= last_edge_d;
      start_q     <= start_d;
      active_q    <= active_d;
      seen_q      <= seen_d;
    end
  end

endmodule

// File: dv/tb_button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press_core
// Self-checking bench for the button debounce and long press core. A local
// model of the button lanes predicts the short and long press masks for every
// accepted beat; results are compared in order. Registers are programmed over
// APB between phases and read back. Directed and random presses run with
// random gaps and stalls on both channels; an output hold-off sends gapless.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_core;
  import bdlp_pkg::*;

  localparam int StallLimit = 4000;

  typedef struct packed {
    logic [PinW-1:0] short_mask;
    logic [PinW-1:0] long_mask;
  } press_report_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             operation_i;
  logic [IdxW-1:0]  button_index_i;
  logic [PinW-1:0]  pin_levels_i;
  logic [TimeW-1:0] now_ms_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [PinW-1:0]  short_press_mask_o;
  logic [PinW-1:0]  long_press_mask_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  cfg_t             press_cfg;
  logic [TimeW-1:0] last_edge_ms [BUTTONS];
  logic [TimeW-1:0] start_ms [BUTTONS];
  logic             btn_active [BUTTONS];
  logic             btn_seen [BUTTONS];
  press_report_t    expected_reports_q[$];

  int               mismatch_count = 0;
  int               idle_cycles = 0;
  int               hold_cycles = 0;
  bit               tx_gaps_off = 0;
  bit               rx_quiet = 0;
  logic [TimeW-1:0] clock_ms;
  logic [PinW-1:0]  pins_down;

  button_debounce_long_press_core u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void reset_press_model();
    press_cfg.bounce_window     = DebounceReset;
    press_cfg.long_press_ms     = LongPressReset;
    press_cfg.short_enable_mask = '0;
    press_cfg.long_enable_mask  = '0;
    foreach (last_edge_ms[b]) begin
      last_edge_ms[b] = '0;
      start_ms[b]     = '0;
      btn_active[b]   = 1'b0;
      btn_seen[b]     = 1'b0;
    end
  endfunction

  function automatic void predict_press_report(op_e op, logic [IdxW-1:0] idx,
                                               logic [PinW-1:0] pins, logic [TimeW-1:0] now);
    press_report_t rep;
    logic [TimeW-1:0] elapsed;
    rep = '0;
    if (op == OP_EDGE) begin
      if (idx < BUTTONS) begin
        elapsed = now - last_edge_ms[idx];
        if (elapsed >= TimeW'(press_cfg.bounce_window)) begin
          last_edge_ms[idx] = now;
          if (!btn_active[idx]) begin
            btn_active[idx] = 1'b1;
            start_ms[idx]   = now;
          end
          btn_seen[idx] = 1'b1;
        end
      end
    end else begin
      for (int b = 0; b < BUTTONS; b++) begin
        if (btn_active[b]) begin
          elapsed = now - start_ms[b];
          if (!pins[b]) begin
            // zero start time never turns long
            if (start_ms[b] != '0 && elapsed > press_cfg.long_press_ms) begin
              rep.long_mask[b] = press_cfg.long_enable_mask[b];
              btn_active[b]    = 1'b0;
              start_ms[b]      = '0;
            end
          end else begin
            rep.short_mask[b] = btn_seen[b] && press_cfg.short_enable_mask[b] &&
                                elapsed <= press_cfg.long_press_ms;
            btn_active[b] = 1'b0;
            btn_seen[b]   = 1'b0;
            start_ms[b]   = '0;
          end
        end
      end
    end
    expected_reports_q.push_back(rep);
  endfunction

  function automatic logic [DataW-1:0] reg_value(reg_idx_e r);
    case (r)
      REG_DEBOUNCE:   return DataW'(press_cfg.bounce_window);
      REG_LONG_PRESS: return DataW'(press_cfg.long_press_ms);
      REG_SHORT_EN:   return DataW'(press_cfg.short_enable_mask);
      default:        return DataW'(press_cfg.long_enable_mask);
    endcase
  endfunction

  // accepted beats on both channels
  always @(posedge clk_i) begin
    press_report_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_press_report(op_e'(operation_i), button_index_i, pin_levels_i, now_ms_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_reports_q.size() == 0) begin
          flag_mismatch($sformatf("result beat short %h long %h with nothing expected",
                                  short_press_mask_o, long_press_mask_o));
        end else begin
          want = expected_reports_q.pop_front();
          if (short_press_mask_o !== want.short_mask)
            flag_mismatch($sformatf("short_press_mask expected %h got %h",
                                    want.short_mask, short_press_mask_o));
          if (long_press_mask_o !== want.long_mask)
            flag_mismatch($sformatf("long_press_mask expected %h got %h",
                                    want.long_mask, long_press_mask_o));
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver stalls: random runs, quiet stretches and a counted hold-off
  initial begin
    int run_left;
    logic run_val;
    out_stall_i = 1'b0;
    run_left = 0;
    run_val = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else if (rx_quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_val = ($urandom_range(0, 2) == 0);
          if (run_val) run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                                 : $urandom_range(1, 3);
          else run_left = $urandom_range(1, 10);
        end
        out_stall_i <= run_val;
        run_left = run_left - 1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_gaps_off || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(op_e op, logic [IdxW-1:0] idx, logic [PinW-1:0] pins,
                           logic [TimeW-1:0] now);
    int gap;
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    button_index_i <= idx;
    pin_levels_i   <= pins;
    now_ms_i       <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_reports();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic expect_reg(reg_idx_e r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'({r, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== reg_value(r))
      flag_mismatch($sformatf("register %s read expected %h got %h",
                              r.name(), reg_value(r), prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_reg(reg_idx_e r, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({r, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_DEBOUNCE:   press_cfg.bounce_window     = value[DebW-1:0];
      REG_LONG_PRESS: press_cfg.long_press_ms     = value[TimeW-1:0];
      REG_SHORT_EN:   press_cfg.short_enable_mask = value[PinW-1:0];
      default:        press_cfg.long_enable_mask  = value[PinW-1:0];
    endcase
    @(posedge clk_i);
    expect_reg(r);
  endtask

  task automatic apply_settings(logic [DebW-1:0] deb, logic [TimeW-1:0] long_ms,
                                logic [PinW-1:0] short_en, logic [PinW-1:0] long_en);
    drain_reports();
    program_reg(REG_DEBOUNCE, DataW'(deb));
    program_reg(REG_LONG_PRESS, DataW'(long_ms));
    program_reg(REG_SHORT_EN, DataW'(short_en));
    program_reg(REG_LONG_EN, DataW'(long_en));
  endtask

  task automatic test_register_defaults();
    expect_reg(REG_DEBOUNCE);
    expect_reg(REG_LONG_PRESS);
    expect_reg(REG_SHORT_EN);
    expect_reg(REG_LONG_EN);
  endtask

  task automatic test_directed_presses();
    apply_settings(16'd50, 32'd1000, 7'h7f, 7'h7f);
    // edge at zero falls inside the debounce window of the reset edge time
    send_beat(OP_EDGE, 3'd0, 7'h00, 32'd0);
    send_beat(OP_EDGE, 3'd0, 7'h7f, 32'd100);
    send_beat(OP_EDGE, 3'd0, 7'h00, 32'd120);
    send_beat(OP_EDGE, 3'd0, 7'h00, 32'd150);
    send_beat(OP_POLL, 3'd7, 7'h7f, 32'd400);
    send_beat(OP_EDGE, 3'd1, 7'h00, 32'd1000);
    send_beat(OP_POLL, 3'd0, 7'h7d, 32'd2000);
    send_beat(OP_POLL, 3'd0, 7'h7d, 32'd2001);
    send_beat(OP_POLL, 3'd0, 7'h7f, 32'd2100);
    // out of range button
    send_beat(OP_EDGE, 3'd7, 7'h00, 32'd5000);
    send_beat(OP_EDGE, 3'd6, 7'h00, 32'hffff_fff0);
    send_beat(OP_POLL, 3'd0, 7'h3f, 32'h0000_0100);
    send_beat(OP_POLL, 3'd0, 7'h7f, 32'h0000_0500);
    send_beat(OP_EDGE, 3'd3, 7'h7f, 32'hffff_ffff);
    send_beat(OP_POLL, 3'd0, 7'h00, 32'hffff_ffff);
    send_beat(OP_POLL, 3'd0, 7'h7f, 32'hffff_ffff);
    apply_settings(16'd0, 32'hffff_ffff, 7'h7f, 7'h7f);
    // press starting at time zero
    send_beat(OP_EDGE, 3'd4, 7'h00, 32'd0);
    send_beat(OP_EDGE, 3'd5, 7'h00, 32'd7);
    send_beat(OP_POLL, 3'd0, 7'h00, 32'h8000_0000);
    send_beat(OP_POLL, 3'd0, 7'h7f, 32'hffff_ffff);
    apply_settings(16'd0, 32'd0, 7'h55, 7'h2a);
    send_beat(OP_EDGE, 3'd2, 7'h00, 32'd10);
    send_beat(OP_EDGE, 3'd1, 7'h00, 32'd10);
    send_beat(OP_POLL, 3'd0, 7'h00, 32'd11);
    send_beat(OP_POLL, 3'd0, 7'h7f, 32'd11);
  endtask

  task automatic test_output_holdoff();
    drain_reports();
    hold_cycles = 80;
    tx_gaps_off = 1'b1;
    for (int n = 0; n < 24; n++) begin
      clock_ms = clock_ms + $urandom_range(0, 60);
      if (n % 3 == 2) send_beat(OP_POLL, IdxW'($urandom), PinW'($urandom), clock_ms);
      else send_beat(OP_EDGE, IdxW'($urandom_range(0, 6)), PinW'($urandom), clock_ms);
    end
    tx_gaps_off = 1'b0;
  endtask

  task automatic test_random_presses();
    logic [IdxW-1:0] idx;
    logic [PinW-1:0] pins;
    int r;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_settings(16'd0, 32'd0, 7'h7f, 7'h7f);
        1: apply_settings(16'hffff, 32'hffff_ffff, 7'h7f, 7'h00);
        default: apply_settings(DebW'($urandom_range(0, 30)), TimeW'($urandom_range(5, 400)),
                                PinW'($urandom), PinW'($urandom));
      endcase
      clock_ms    = (phase == 1) ? 32'hffff_f000 : $urandom;
      pins_down   = '0;
      tx_gaps_off = (phase == 3);
      rx_quiet    = (phase == 4);
      for (int n = 0; n < 65; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80) clock_ms = clock_ms + $urandom_range(0, 40);
        else if (r < 97) clock_ms = clock_ms + $urandom_range(41, 3000);
        else clock_ms = $urandom;
        if ($urandom_range(0, 99) < 45) begin
          idx = ($urandom_range(0, 19) == 0) ? IdxW'(7) : IdxW'($urandom_range(0, 6));
          if (idx < BUTTONS) pins_down[idx] = 1'b1;
          send_beat(OP_EDGE, idx, PinW'($urandom), clock_ms);
        end else begin
          if ($urandom_range(0, 9) < 3) pins_down = pins_down & PinW'($urandom);
          pins = ($urandom_range(0, 9) == 0) ? PinW'($urandom) : ~pins_down;
          send_beat(OP_POLL, IdxW'($urandom), pins, clock_ms);
        end
      end
    end
    tx_gaps_off = 1'b0;
    rx_quiet    = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = 1'b0;
    button_index_i = '0;
    pin_levels_i   = '1;
    now_ms_i       = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    clock_ms       = '0;
    pins_down      = '0;
    reset_press_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_directed_presses();
    clock_ms = 32'd20000;
    test_output_holdoff();
    test_random_presses();
    drain_reports();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bdlp_pkg.sv
hdl/bdlp_cfg.sv
hdl/bdlp_lane.sv
hdl/button_debounce_long_press_core.sv
dv/tb_button_debounce_long_press_core.sv
